### hdl/sma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine ALU package
// Request and result types, operation and error codes, controller states and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sma_pkg;

	localparam logic [4:0] OP_PUSH    = 5'd0;
	localparam logic [4:0] OP_PUSHF   = 5'd1;
	localparam logic [4:0] OP_DROP    = 5'd2;
	localparam logic [4:0] OP_DUP     = 5'd3;
	localparam logic [4:0] OP_EQ      = 5'd4;
	localparam logic [4:0] OP_LTU     = 5'd5;
	localparam logic [4:0] OP_LTS     = 5'd6;
	localparam logic [4:0] OP_GTU     = 5'd7;
	localparam logic [4:0] OP_GTS     = 5'd8;
	localparam logic [4:0] OP_LEU     = 5'd9;
	localparam logic [4:0] OP_LES     = 5'd10;
	localparam logic [4:0] OP_GEU     = 5'd11;
	localparam logic [4:0] OP_GES     = 5'd12;
	localparam logic [4:0] OP_ADD     = 5'd13;
	localparam logic [4:0] OP_ADDC    = 5'd14;
	localparam logic [4:0] OP_ADDS    = 5'd15;
	localparam logic [4:0] OP_SUB     = 5'd16;
	localparam logic [4:0] OP_SUBS    = 5'd17;
	localparam logic [4:0] OP_MUL     = 5'd18;
	localparam logic [4:0] OP_MULS    = 5'd19;
	localparam logic [4:0] OP_WORDS   = 5'd20;
	localparam logic [4:0] OP_BITMASK = 5'd21;
	localparam logic [4:0] OP_NOP     = 5'd22;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_NUM   = 2'd1;
	localparam logic [1:0] ERR_UNDER = 2'd2;
	localparam logic [1:0] ERR_OVER  = 2'd3;

	localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

	localparam logic [2:0] MUL_LAST = 3'd4;

	typedef struct packed {
		logic [4:0]  op;
		logic [63:0] literal;
	} req_t;

	typedef struct packed {
		logic [63:0] top_value;
		logic [4:0]  stack_depth;
		logic        cond_flag;
		logic [1:0]  error_code;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_MFIN
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul_start;
		logic       mul_step;
		logic [2:0] mul_idx;
		logic       commit;
	} cmd_t;

	typedef struct packed {
		logic go_mul;
	} sts_t;

	// Smallest mask of the form 2^k-1 that is not below x.
	function automatic logic [63:0] max_mask(input logic [63:0] x);
		logic [63:0] m;
		m = x;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		m = m | (m >> 16);
		m = m | (m >> 32);
		return m;
	endfunction

endpackage

### hdl/sma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/sma_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine ALU controller
// Sequences request intake, execution, the multi-cycle multiply and the
// commit into the result register.
// ----------------------------------------------------------------------------
module sma_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          res_valid,
	input  logic          res_stall,
	input  sma_pkg::sts_t sts,
	output sma_pkg::cmd_t cmd
);

	import sma_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [2:0] mcnt_q;
	logic [2:0] mcnt_d;
	logic       res_valid_q;
	logic       room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mcnt_q  <= mcnt_d;
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		room          = !res_valid_q || !res_stall;
		state_d       = state_q;
		mcnt_d        = mcnt_q;
		cmd.load      = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.mul_step  = 1'b0;
		cmd.mul_idx   = mcnt_q;
		cmd.commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.go_mul) begin
					cmd.mul_start = 1'b1;
					mcnt_d        = '0;
					state_d       = ST_MUL;
				end else if (room) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				mcnt_d       = mcnt_q + 3'd1;
				if (mcnt_q == MUL_LAST) begin
					state_d = ST_MFIN;
				end
			end
			ST_MFIN: begin
				if (room) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

`ifndef SYNTH
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mcnt_q == MUL_LAST) |=> (state_q == ST_MFIN))
		else $error("multiply sequence did not finish after the last step");

	a_res_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(cmd.commit))
		else $error("result shown without a commit");
`endif

endmodule

### hdl/sma_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine ALU datapath
// Holds the stack RAM, depth, flag, error and cached top of stack, and
// computes the effect of one operation, with a 32x32 multiplier that accumulates partial products.
// ----------------------------------------------------------------------------
module sma_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sma_pkg::req_t req,
	input  sma_pkg::cmd_t cmd,
	output sma_pkg::sts_t sts,
	output sma_pkg::rsp_t res
);

	import sma_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [4:0]   op_q;
	logic [63:0]  lit_q;
	logic [DW-1:0] depth_q;
	logic         flag_q;
	logic [1:0]   err_q;
	logic [63:0]  top_q;
	logic [63:0]  ma_q;
	logic [63:0]  mb_q;
	logic         neg_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	rsp_t         res_q;

	logic [63:0]  a;
	logic [63:0]  b;
	logic [63:0]  ram_rdata;
	logic [AW-1:0] a_push;
	logic [AW-1:0] a_top;
	logic [AW-1:0] a_nos;
	logic [DW-1:0] d_inc;
	logic [DW-1:0] d_dec;
	logic [1:0]   need;
	logic         grows;
	logic         full;
	logic         is_signed_mul;

	logic [64:0]  sum;
	logic [63:0]  diff;
	logic [63:0]  ar_r;
	logic         ar_ovf;
	logic         cmp_flag;
	logic [63:0]  mul_lo;
	logic [63:0]  mul_r;
	logic         mul_ovf;
	logic [31:0]  mul_x;
	logic [31:0]  mul_y;
	logic [1:0]   prev_idx;
	logic [127:0] pp_shifted;

	logic [DW-1:0] n_depth;
	logic         n_flag;
	logic [1:0]   n_err;
	logic [63:0]  n_top;
	logic         wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0]  wr_data;

	assign a      = ram_rdata;
	assign b      = top_q;
	assign d_inc  = depth_q + DW'(1);
	assign d_dec  = depth_q - DW'(1);
	assign a_push = AW'(depth_q);
	assign a_top  = AW'(d_dec);
	assign a_nos  = AW'(depth_q - DW'(2));
	assign full   = (depth_q == DW'(STACK_DEPTH));

	sma_ram #(
		.WIDTH(64),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (wr_en && cmd.commit),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(a_nos),
		.rdata(ram_rdata)
	);

	always_comb begin
		grows = (op_q == OP_PUSH) || (op_q == OP_PUSHF) || (op_q == OP_DUP);
		if (op_q == OP_PUSH || op_q == OP_PUSHF) begin
			need = 2'd0;
		end else if (op_q == OP_DROP || op_q == OP_DUP || op_q >= OP_WORDS) begin
			need = 2'd1;
		end else begin
			need = 2'd2;
		end
	end

	assign is_signed_mul = (op_q == OP_MULS);
	assign sts.go_mul = (err_q == ERR_NONE) && (op_q == OP_MUL || op_q == OP_MULS) &&
		(depth_q >= DW'(2));

	assign mul_lo  = acc_q[63:0];
	assign mul_r   = neg_q ? (64'd0 - mul_lo) : mul_lo;
	assign mul_ovf = (acc_q[127:64] != 64'd0) ||
		(is_signed_mul && (neg_q ? (mul_lo > SIGN64) : (mul_lo >= SIGN64)));

	assign mul_x    = cmd.mul_idx[1] ? ma_q[63:32] : ma_q[31:0];
	assign mul_y    = cmd.mul_idx[0] ? mb_q[63:32] : mb_q[31:0];
	assign prev_idx = 2'(cmd.mul_idx - 3'd1);

	always_comb begin
		unique case (prev_idx)
			2'd0:    pp_shifted = {64'd0, pp_q};
			2'd1,
			2'd2:    pp_shifted = {32'd0, pp_q, 32'd0};
			default: pp_shifted = {pp_q, 64'd0};
		endcase
	end

	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = a - b;

	always_comb begin
		ar_r   = sum[63:0];
		ar_ovf = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				ar_ovf = sum[64];
			end
			OP_ADDS: begin
				ar_ovf = (a[63] ^ sum[63]) & (b[63] ^ sum[63]);
			end
			OP_SUB: begin
				ar_r   = diff;
				ar_ovf = (b > a);
			end
			OP_SUBS: begin
				ar_r   = diff;
				ar_ovf = (a[63] ^ b[63]) & (a[63] ^ diff[63]);
			end
			OP_MUL,
			OP_MULS: begin
				ar_r   = mul_r;
				ar_ovf = mul_ovf;
			end
			default: begin
				ar_ovf = 1'b0;
			end
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_LTU:  cmp_flag = (a < b);
			OP_LTS:  cmp_flag = ($signed(a) < $signed(b));
			OP_GTU:  cmp_flag = (a > b);
			OP_GTS:  cmp_flag = ($signed(a) > $signed(b));
			OP_LEU:  cmp_flag = (a <= b);
			OP_LES:  cmp_flag = ($signed(a) <= $signed(b));
			OP_GEU:  cmp_flag = (a >= b);
			default: cmp_flag = ($signed(a) >= $signed(b));
		endcase
	end

	always_comb begin
		n_depth = depth_q;
		n_flag  = flag_q;
		n_err   = err_q;
		n_top   = top_q;
		wr_en   = 1'b0;
		wr_addr = a_top;
		wr_data = top_q;
		if (err_q == ERR_NONE && op_q <= OP_BITMASK) begin
			if (depth_q < DW'(need)) begin
				n_err = ERR_UNDER;
			end else if (grows && full) begin
				n_err = ERR_OVER;
			end else begin
				unique case (op_q)
					OP_PUSH: begin
						wr_en   = 1'b1;
						wr_addr = a_push;
						wr_data = lit_q;
						n_depth = d_inc;
						n_top   = lit_q;
					end
					OP_PUSHF: begin
						wr_en   = 1'b1;
						wr_addr = a_push;
						wr_data = 64'(flag_q);
						n_depth = d_inc;
						n_top   = 64'(flag_q);
					end
					OP_DROP: begin
						n_depth = d_dec;
						n_top   = (depth_q >= DW'(2)) ? a : 64'd0;
					end
					OP_DUP: begin
						wr_en   = 1'b1;
						wr_addr = a_push;
						wr_data = top_q;
						n_depth = d_inc;
					end
					OP_EQ: begin
						wr_en   = 1'b1;
						wr_addr = a_top;
						wr_data = 64'(a == b);
						n_top   = 64'(a == b);
					end
					OP_LTU, OP_LTS, OP_GTU, OP_GTS,
					OP_LEU, OP_LES, OP_GEU, OP_GES: begin
						n_flag  = cmp_flag;
						n_depth = d_dec;
						n_top   = a;
					end
					OP_ADD, OP_ADDC, OP_ADDS, OP_SUB,
					OP_SUBS, OP_MUL, OP_MULS: begin
						if (ar_ovf) begin
							n_err = ERR_NUM;
						end else begin
							wr_en   = 1'b1;
							wr_addr = a_nos;
							wr_data = ar_r;
							n_depth = d_dec;
							n_top   = ar_r;
							if (op_q == OP_ADDC) begin
								n_flag = sum[64];
							end
						end
					end
					OP_WORDS: begin
						if (b[63:61] != 3'd0) begin
							n_err = ERR_NUM;
						end else begin
							wr_en   = 1'b1;
							wr_addr = a_top;
							wr_data = {b[60:0], 3'd0};
							n_top   = {b[60:0], 3'd0};
						end
					end
					OP_BITMASK: begin
						wr_en   = 1'b1;
						wr_addr = a_top;
						wr_data = max_mask(b);
						n_top   = max_mask(b);
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.op;
			lit_q <= req.literal;
		end
		if (cmd.mul_start) begin
			ma_q  <= (is_signed_mul && a[63]) ? (64'd0 - a) : a;
			mb_q  <= (is_signed_mul && b[63]) ? (64'd0 - b) : b;
			neg_q <= is_signed_mul && (a[63] ^ b[63]);
			acc_q <= '0;
		end else if (cmd.mul_step) begin
			if (cmd.mul_idx != MUL_LAST) begin
				pp_q <= {32'd0, mul_x} * {32'd0, mul_y};
			end
			if (cmd.mul_idx != 3'd0) begin
				acc_q <= acc_q + pp_shifted;
			end
		end
		if (cmd.commit) begin
			res_q.top_value   <= n_top;
			res_q.stack_depth <= 5'(n_depth);
			res_q.cond_flag   <= n_flag;
			res_q.error_code  <= n_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			flag_q  <= 1'b0;
			err_q   <= ERR_NONE;
			top_q   <= '0;
		end else if (cmd.commit) begin
			depth_q <= n_depth;
			flag_q  <= n_flag;
			err_q   <= n_err;
			top_q   <= n_top;
		end
	end

	assign res = res_q;

`ifndef SYNTH
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |=> (err_q == $past(err_q)))
		else $error("error code changed after being set");

	a_err_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |=> ($stable(depth_q) && $stable(top_q) && $stable(flag_q)))
		else $error("stack state changed while an error is held");
`endif

endmodule

### hdl/stack_machine_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine ALU
// Requests are handled one at a time: a new request is taken only after the
// previous result is committed into the result register. Multiply runs
// operand setup, four 32x32 partial products and their accumulation, then
// a check; a commit waits while the result register is full and stalled.
// The next request is taken while the previous result waits in its register.
// Reset clears depth, flag, error code and top of stack; the stack RAM is
// not cleared.
// ----------------------------------------------------------------------------
module stack_machine_alu #(
	parameter int STACK_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sma_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_stall,
	output sma_pkg::rsp_t res
);

	import sma_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sma_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.res   (res)
	);

endmodule
